FILE: sv/pps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Shared widths, opcodes and the records passed between the top level and
// the task cells.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int unsigned MAX_TASKS_DEF = 16;
  localparam int unsigned TIME_BITS_DEF = 20;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned SLOT_IN_W  = 4;
  localparam int unsigned PID_W      = 16;
  localparam int unsigned ARR_W      = 20;
  localparam int unsigned BURST_W    = 16;
  localparam int unsigned PRIO_W     = 8;
  localparam int unsigned OUT_TIME_W = 20;
  localparam int unsigned USED_W     = 21;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [PID_W-1:0]   pid;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } task_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic run;
  } pps_ctrl_t;

  typedef struct packed {
    logic              found;
    logic [PRIO_W-1:0] prio;
    logic [PID_W-1:0]  pid;
    logic              last;
    logic [USED_W-1:0] used;
  } cand_t;

endpackage

FILE: sv/pps_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler task cell
// Holds one table slot and compares it against the candidate handed on by
// the previous cell, passing the better one to the next cell every cycle.
// ----------------------------------------------------------------------------
module pps_cell #(
  parameter int unsigned MAX_TASKS = pps_pkg::MAX_TASKS_DEF,
  parameter int unsigned TIME_BITS = pps_pkg::TIME_BITS_DEF,
  parameter int unsigned CELL_IDX  = 0,
  localparam int unsigned SLOT_W   = $clog2(MAX_TASKS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pps_pkg::pps_ctrl_t    ctrl_i,
  input  pps_pkg::task_t        task_i,
  input  logic [TIME_BITS-1:0]  clock_i,
  input  pps_pkg::cand_t        cand_i,
  input  logic [SLOT_W-1:0]     cand_slot_i,
  output pps_pkg::cand_t        cand_o,
  output logic [SLOT_W-1:0]     cand_slot_o,
  output logic                  valid_o,
  output logic                  done_o
);
  import pps_pkg::*;

  localparam int unsigned CMP_W = (TIME_BITS > ARR_W) ? TIME_BITS : ARR_W;

  logic                valid_q, done_q;
  logic [PID_W-1:0]    pid_q;
  logic [ARR_W-1:0]    arr_q;
  logic [PRIO_W-1:0]   prio_q;
  logic [USED_W-1:0]   used_q;
  logic [BURST_W-1:0]  rem_q;
  logic                eligible, better;
  cand_t               own, cand_d, cand_q;
  logic [SLOT_W-1:0]   slot_d, slot_q;

  assign eligible = valid_q & ~done_q & (CMP_W'(arr_q) <= CMP_W'(clock_i));

  always_comb begin
    own.found = 1'b1;
    own.prio  = prio_q;
    own.pid   = pid_q;
    own.last  = (rem_q == BURST_W'(1));
    own.used  = used_q;
  end

  assign better = eligible && (!cand_i.found || (prio_q < cand_i.prio) ||
                  ((prio_q == cand_i.prio) && (pid_q < cand_i.pid)));

  assign cand_d = better ? own : cand_i;
  assign slot_d = better ? SLOT_W'(CELL_IDX) : cand_slot_i;

  // advance the candidate one cell
  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    slot_q <= slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else if (ctrl_i.load) begin
      valid_q <= 1'b1;
      done_q  <= (task_i.burst == '0);
    end else if (ctrl_i.run && (rem_q == BURST_W'(1))) begin
      done_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      pid_q  <= task_i.pid;
      arr_q  <= task_i.arrival;
      prio_q <= task_i.prio;
      rem_q  <= task_i.burst;
      used_q <= USED_W'(task_i.arrival) + USED_W'(task_i.burst);
    end else if (ctrl_i.run) begin
      rem_q  <= rem_q - BURST_W'(1);
    end
  end

  assign cand_o      = cand_q;
  assign cand_slot_o = slot_q;
  assign valid_o     = valid_q;
  assign done_o      = done_q;

endmodule

FILE: sv/preemptive_priority_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler unit
// Load, clear and no-op transactions: the result appears in the cycle after the
// transaction; the next transaction may be accepted at that same edge.
// Tick transactions: the unit steps through its scan state while the candidate
// travels one cell per cycle along the chain of task cells, then its apply
// state, which registers the result; busy holds transactions off until then.
// Reset empties the table, zeroes the clock and forgets the last task run;
// results carry a one-cycle strobe and the receiver cannot stall.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_unit #(
  parameter int unsigned MAX_TASKS = pps_pkg::MAX_TASKS_DEF,
  parameter int unsigned TIME_BITS = pps_pkg::TIME_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  input  logic [pps_pkg::OP_W-1:0]         opcode_i,
  input  logic [pps_pkg::SLOT_IN_W-1:0]    slot_i,
  input  logic [pps_pkg::PID_W-1:0]        process_id_i,
  input  logic [pps_pkg::ARR_W-1:0]        arrival_time_i,
  input  logic [pps_pkg::BURST_W-1:0]      burst_length_i,
  input  logic [pps_pkg::PRIO_W-1:0]       priority_level_i,
  output logic                             busy,
  output logic                             valid_o,
  output logic [pps_pkg::OUT_TIME_W-1:0]   tick_start_o,
  output logic                             busy_res_o,
  output logic                             dispatched_o,
  output logic [pps_pkg::PID_W-1:0]        running_process_o,
  output logic                             finished_o,
  output logic [pps_pkg::OUT_TIME_W-1:0]   finish_time_o,
  output logic [pps_pkg::OUT_TIME_W-1:0]   wait_time_o,
  output logic                             all_done_o
);
  import pps_pkg::*;

  localparam int unsigned SLOT_W = $clog2(MAX_TASKS);
  localparam int unsigned PEND_W = $clog2(MAX_TASKS + 1);
  localparam int unsigned EXT_W  = (TIME_BITS > USED_W) ? TIME_BITS : USED_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [SLOT_W-1:0]     cnt_q, cnt_d;
  logic [TIME_BITS-1:0]  clock_q, clock_d, clock_inc;
  logic [PEND_W-1:0]     pend_q, pend_d;
  logic                  last_vld_q, last_vld_d;
  logic [SLOT_W-1:0]     last_slot_q, last_slot_d;

  logic                  res_valid_q, res_valid_d;
  logic [OUT_TIME_W-1:0] res_start_q, res_start_d;
  logic                  res_busy_q, res_busy_d;
  logic                  res_disp_q, res_disp_d;
  logic [PID_W-1:0]      res_pid_q, res_pid_d;
  logic                  res_fin_q, res_fin_d;
  logic [OUT_TIME_W-1:0] res_ftime_q, res_ftime_d;
  logic [OUT_TIME_W-1:0] res_wait_q, res_wait_d;
  logic                  res_all_q, res_all_d;

  logic                  accept, load_go, clear_go, apply, in_range, old_pend;
  logic [SLOT_W-1:0]     slot_idx;
  logic [EXT_W-1:0]      clk_now_ext, clk_next_ext, used_ext;
  task_t                 task_in;
  cand_t                 chain     [MAX_TASKS+1];
  logic [SLOT_W-1:0]     chain_slot[MAX_TASKS+1];
  cand_t                 best;
  logic [SLOT_W-1:0]     best_slot;
  logic [MAX_TASKS-1:0]  valid_vec, done_vec;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start & ~busy;
  assign load_go  = accept && (opcode_i == OP_LOAD);
  assign clear_go = accept && (opcode_i == OP_CLEAR);
  assign apply    = (state_q == ST_APPLY);
  assign in_range = (32'(slot_i) < MAX_TASKS);
  assign slot_idx = SLOT_W'(slot_i);
  assign old_pend = in_range ? (valid_vec[slot_idx] & ~done_vec[slot_idx]) : 1'b0;

  always_comb begin
    task_in.pid     = process_id_i;
    task_in.arrival = arrival_time_i;
    task_in.burst   = burst_length_i;
    task_in.prio    = priority_level_i;
  end

  assign chain[0]      = '0;
  assign chain_slot[0] = '0;
  assign best          = chain[MAX_TASKS];
  assign best_slot     = chain_slot[MAX_TASKS];

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    pps_ctrl_t ctrl;

    always_comb begin
      ctrl.load  = load_go && in_range && (32'(slot_i) == i);
      ctrl.clear = clear_go;
      ctrl.run   = apply && best.found && (32'(best_slot) == i);
    end

    pps_cell #(
      .MAX_TASKS (MAX_TASKS),
      .TIME_BITS (TIME_BITS),
      .CELL_IDX  (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .task_i      (task_in),
      .clock_i     (clock_q),
      .cand_i      (chain[i]),
      .cand_slot_i (chain_slot[i]),
      .cand_o      (chain[i+1]),
      .cand_slot_o (chain_slot[i+1]),
      .valid_o     (valid_vec[i]),
      .done_o      (done_vec[i])
    );
  end

  assign clock_inc    = (clock_q == '1) ? clock_q : clock_q + TIME_BITS'(1);
  assign clk_now_ext  = EXT_W'(clock_q);
  assign clk_next_ext = EXT_W'(clock_inc);
  assign used_ext     = EXT_W'(best.used);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    clock_d     = clock_q;
    pend_d      = pend_q;
    last_vld_d  = last_vld_q;
    last_slot_d = last_slot_q;
    res_valid_d = 1'b0;
    res_start_d = clk_now_ext[OUT_TIME_W-1:0];
    res_busy_d  = 1'b0;
    res_disp_d  = 1'b0;
    res_pid_d   = '0;
    res_fin_d   = 1'b0;
    res_ftime_d = '0;
    res_wait_d  = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (opcode_i)
            OP_LOAD: begin
              res_valid_d = 1'b1;
              if (in_range) begin
                pend_d = pend_q - PEND_W'(old_pend) + PEND_W'(burst_length_i != '0);
                if (last_vld_q && (32'(last_slot_q) == 32'(slot_i))) begin
                  last_vld_d = 1'b0;
                end
              end
            end
            OP_CLEAR: begin
              res_valid_d = 1'b1;
              clock_d     = '0;
              pend_d      = '0;
              last_vld_d  = 1'b0;
            end
            OP_TICK: begin
              state_d = ST_SCAN;
              cnt_d   = '0;
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + SLOT_W'(1);
        if (cnt_q == SLOT_W'(MAX_TASKS - 1)) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        state_d     = ST_IDLE;
        clock_d     = clock_inc;
        res_valid_d = 1'b1;
        if (best.found) begin
          res_busy_d  = 1'b1;
          res_disp_d  = !(last_vld_q && (last_slot_q == best_slot));
          res_pid_d   = best.pid;
          last_vld_d  = !best.last;
          last_slot_d = best_slot;
          if (best.last) begin
            res_fin_d   = 1'b1;
            pend_d      = pend_q - PEND_W'(1);
            res_ftime_d = clk_next_ext[OUT_TIME_W-1:0];
            if (clk_next_ext > used_ext) begin
              res_wait_d = OUT_TIME_W'(clk_next_ext - used_ext);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_all_d = (pend_d == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      clock_q     <= '0;
      pend_q      <= '0;
      last_vld_q  <= 1'b0;
      last_slot_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      clock_q     <= clock_d;
      pend_q      <= pend_d;
      last_vld_q  <= last_vld_d;
      last_slot_q <= last_slot_d;
      res_valid_q <= res_valid_d;
    end
  end

  // hold the result for its strobe cycle
  always_ff @(posedge clk_i) begin
    res_start_q <= res_start_d;
    res_busy_q  <= res_busy_d;
    res_disp_q  <= res_disp_d;
    res_pid_q   <= res_pid_d;
    res_fin_q   <= res_fin_d;
    res_ftime_q <= res_ftime_d;
    res_wait_q  <= res_wait_d;
    res_all_q   <= res_all_d;
  end

  assign valid_o           = res_valid_q;
  assign tick_start_o      = res_start_q;
  assign busy_res_o        = res_busy_q;
  assign dispatched_o      = res_disp_q;
  assign running_process_o = res_pid_q;
  assign finished_o        = res_fin_q;
  assign finish_time_o     = res_ftime_q;
  assign wait_time_o       = res_wait_q;
  assign all_done_o        = res_all_q;

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($past(state_q) == ST_APPLY) ||
                ($past(accept) && ($past(opcode_i) != OP_TICK)))
    else $error("result strobe without a completed transaction");

  a_finish_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_o |-> (valid_o && busy_res_o))
    else $error("completion reported without a running task");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pend_q) <= MAX_TASKS)
    else $error("pending task count out of range");

  a_all_done_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && all_done_o) |-> (pend_q == '0))
    else $error("all done reported with tasks pending");

endmodule

FILE: tb/preemptive_priority_scheduler_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Preemptive priority scheduler unit test
// Drives load, tick, clear and no-op transactions into the scheduler and
// checks every result strobe against a local model of the task table. A short
// directed run covers field extremes, ties, preemption, zero bursts and slot
// reloads; the random run is mostly clean load-then-tick schedules with
// random gaps, mixed with stray commands.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_unit_test;
  import pps_pkg::*;

  localparam int NTASK          = MAX_TASKS_DEF;
  localparam int NO_SLOT        = NTASK;
  localparam int ITEM_TARGET    = 850;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    opcode_e              op;
    logic [SLOT_IN_W-1:0] slot;
    logic [PID_W-1:0]     pid;
    logic [ARR_W-1:0]     arrival;
    logic [BURST_W-1:0]   burst;
    logic [PRIO_W-1:0]    prio;
    int                   gap;
    bit                   hold;
  } sched_cmd_t;

  typedef struct packed {
    logic [OUT_TIME_W-1:0] tick_start;
    logic                  busy_res;
    logic                  dispatched;
    logic [PID_W-1:0]      running_process;
    logic                  finished;
    logic [OUT_TIME_W-1:0] finish_time;
    logic [OUT_TIME_W-1:0] wait_time;
    logic                  all_done;
  } sched_outcome_t;

  logic                  clk_i            = 1'b0;
  logic                  rst_ni           = 1'b0;
  logic                  start            = 1'b0;
  logic [OP_W-1:0]       opcode_i         = OP_NOP;
  logic [SLOT_IN_W-1:0]  slot_i           = '0;
  logic [PID_W-1:0]      process_id_i     = '0;
  logic [ARR_W-1:0]      arrival_time_i   = '0;
  logic [BURST_W-1:0]    burst_length_i   = '0;
  logic [PRIO_W-1:0]     priority_level_i = '0;
  logic                  busy;
  logic                  valid_o;
  logic [OUT_TIME_W-1:0] tick_start_o;
  logic                  busy_res_o;
  logic                  dispatched_o;
  logic [PID_W-1:0]      running_process_o;
  logic                  finished_o;
  logic [OUT_TIME_W-1:0] finish_time_o;
  logic [OUT_TIME_W-1:0] wait_time_o;
  logic                  all_done_o;

  sched_cmd_t     pending_cmds[$];
  sched_outcome_t pending_outcomes[$];
  sched_cmd_t     cur_cmd;
  bit             have_cmd     = 1'b0;
  int             gap_left     = 0;
  int             outstanding  = 0;
  int             quiet_cycles = 0;
  int             mismatches   = 0;

  // generator state
  int idle_mode = 1;
  bit hold_next = 1'b0;
  int n_items   = 0;
  int gen_clock = 0;

  // run statistics
  int n_accepted = 0;
  int n_ticks    = 0;
  int n_idle     = 0;
  int n_dispatch = 0;
  int n_finish   = 0;

  // scheduler table model
  bit                  tbl_valid   [NTASK];
  bit                  tbl_done    [NTASK];
  logic [PID_W-1:0]    tbl_pid     [NTASK];
  logic [ARR_W-1:0]    tbl_arrival [NTASK];
  logic [BURST_W-1:0]  tbl_burst   [NTASK];
  logic [PRIO_W-1:0]   tbl_prio    [NTASK];
  logic [BURST_W-1:0]  tbl_left    [NTASK];
  logic [TIME_BITS_DEF-1:0] sim_clock = '0;
  int                  prev_slot = NO_SLOT;

  preemptive_priority_scheduler_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .opcode_i          (opcode_i),
    .slot_i            (slot_i),
    .process_id_i      (process_id_i),
    .arrival_time_i    (arrival_time_i),
    .burst_length_i    (burst_length_i),
    .priority_level_i  (priority_level_i),
    .busy              (busy),
    .valid_o           (valid_o),
    .tick_start_o      (tick_start_o),
    .busy_res_o        (busy_res_o),
    .dispatched_o      (dispatched_o),
    .running_process_o (running_process_o),
    .finished_o        (finished_o),
    .finish_time_o     (finish_time_o),
    .wait_time_o       (wait_time_o),
    .all_done_o        (all_done_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic sched_outcome_t run_scheduler_step(sched_cmd_t c);
    sched_outcome_t r;
    int best;
    int used;
    int now;
    r = '0;
    r.tick_start = sim_clock;
    case (c.op)
      OP_LOAD: begin
        tbl_valid[c.slot]   = 1'b1;
        tbl_pid[c.slot]     = c.pid;
        tbl_arrival[c.slot] = c.arrival;
        tbl_burst[c.slot]   = c.burst;
        tbl_prio[c.slot]    = c.prio;
        tbl_left[c.slot]    = c.burst;
        tbl_done[c.slot]    = (c.burst == '0);
        if (prev_slot == int'(c.slot)) prev_slot = NO_SLOT;
      end
      OP_CLEAR: begin
        tbl_valid = '{default: 1'b0};
        tbl_done  = '{default: 1'b0};
        sim_clock = '0;
        prev_slot = NO_SLOT;
      end
      OP_TICK: begin
        best = NO_SLOT;
        for (int i = 0; i < NTASK; i++) begin
          if (tbl_valid[i] && !tbl_done[i] && tbl_left[i] != '0 &&
              tbl_arrival[i] <= sim_clock) begin
            if (best == NO_SLOT || tbl_prio[i] < tbl_prio[best] ||
                (tbl_prio[i] == tbl_prio[best] && tbl_pid[i] < tbl_pid[best]))
              best = i;
          end
        end
        if (sim_clock != '1) sim_clock = sim_clock + TIME_BITS_DEF'(1);
        if (best != NO_SLOT) begin
          r.busy_res        = 1'b1;
          r.dispatched      = (best != prev_slot);
          r.running_process = tbl_pid[best];
          prev_slot         = best;
          tbl_left[best]    = tbl_left[best] - BURST_W'(1);
          if (tbl_left[best] == '0) begin
            used           = int'(tbl_arrival[best]) + int'(tbl_burst[best]);
            now            = int'(sim_clock);
            tbl_done[best] = 1'b1;
            prev_slot      = NO_SLOT;
            r.finished     = 1'b1;
            r.finish_time  = sim_clock;
            r.wait_time    = (now > used) ? OUT_TIME_W'(now - used) : '0;
          end
        end
      end
      default: ;
    endcase
    r.all_done = 1'b1;
    for (int i = 0; i < NTASK; i++)
      if (tbl_valid[i] && !tbl_done[i]) r.all_done = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  function automatic int draw_gap();
    case (idle_mode)
      0:       return 0;
      1:       return $urandom_range(0, 19);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 19) : 0;
    endcase
  endfunction

  task automatic push_cmd(opcode_e op, logic [SLOT_IN_W-1:0] slot, logic [PID_W-1:0] pid,
                          logic [ARR_W-1:0] arrival, logic [BURST_W-1:0] burst,
                          logic [PRIO_W-1:0] prio);
    sched_cmd_t c;
    c.op      = op;
    c.slot    = slot;
    c.pid     = pid;
    c.arrival = arrival;
    c.burst   = burst;
    c.prio    = prio;
    c.gap     = draw_gap();
    c.hold    = hold_next;
    hold_next = 1'b0;
    pending_cmds.push_back(c);
    n_items++;
    if (op == OP_TICK) gen_clock++;
    if (op == OP_CLEAR) gen_clock = 0;
  endtask

  task automatic load_random_task(inout int span);
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] bl;
    logic [PID_W-1:0]   pid;
    logic [PRIO_W-1:0]  prio;
    arr = ARR_W'(gen_clock + $urandom_range(0, 8));
    if ($urandom_range(0, 19) == 0) arr = ARR_W'($urandom);
    bl = BURST_W'($urandom_range(1, 6));
    case ($urandom_range(0, 29))
      0:       bl = BURST_W'($urandom);
      1:       bl = '0;
      default: ;
    endcase
    pid  = $urandom_range(0, 1) ? PID_W'($urandom_range(0, 3)) : PID_W'($urandom);
    prio = ($urandom_range(0, 3) != 0) ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom);
    push_cmd(OP_LOAD, SLOT_IN_W'($urandom), pid, arr, bl, prio);
    if (int'(bl) <= 6) span += int'(bl);
  endtask

  // driver: present the next transaction after its gap
  always @(posedge clk_i) begin : driver
    logic raise;
    if (rst_ni) begin
      raise = start;
      if (start && !busy) begin
        raise    = 1'b0;
        have_cmd = 1'b0;
      end
      if (!have_cmd && pending_cmds.size() != 0) begin
        cur_cmd  = pending_cmds.pop_front();
        have_cmd = 1'b1;
        gap_left = cur_cmd.gap;
      end
      if (have_cmd && !raise) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!cur_cmd.hold || (outstanding == 0 && !(start && !busy))) begin
          opcode_i         <= cur_cmd.op;
          slot_i           <= cur_cmd.slot;
          process_id_i     <= cur_cmd.pid;
          arrival_time_i   <= cur_cmd.arrival;
          burst_length_i   <= cur_cmd.burst;
          priority_level_i <= cur_cmd.prio;
          raise = 1'b1;
        end
      end
      start <= raise;
    end
  end

  // monitor: check result strobes, then predict the transaction just taken
  always @(posedge clk_i) begin : monitor
    sched_outcome_t want;
    sched_cmd_t     seen;
    if (rst_ni) begin
      if (valid_o) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch("result strobe with no transaction outstanding");
        end else begin
          want = pending_outcomes.pop_front();
          check_field("tick_start", 32'(tick_start_o), 32'(want.tick_start));
          check_field("busy_res", 32'(busy_res_o), 32'(want.busy_res));
          check_field("dispatched", 32'(dispatched_o), 32'(want.dispatched));
          check_field("running_process", 32'(running_process_o),
                      32'(want.running_process));
          check_field("finished", 32'(finished_o), 32'(want.finished));
          check_field("finish_time", 32'(finish_time_o), 32'(want.finish_time));
          check_field("wait_time", 32'(wait_time_o), 32'(want.wait_time));
          check_field("all_done", 32'(all_done_o), 32'(want.all_done));
        end
      end
      if (start && !busy) begin
        seen.op      = opcode_e'(opcode_i);
        seen.slot    = slot_i;
        seen.pid     = process_id_i;
        seen.arrival = arrival_time_i;
        seen.burst   = burst_length_i;
        seen.prio    = priority_level_i;
        seen.gap     = 0;
        seen.hold    = 1'b0;
        want = run_scheduler_step(seen);
        pending_outcomes.push_back(want);
        n_accepted++;
        if (seen.op == OP_TICK) begin
          n_ticks++;
          if (!want.busy_res) n_idle++;
          if (want.dispatched) n_dispatch++;
          if (want.finished) n_finish++;
        end
      end
      outstanding <= pending_outcomes.size();
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((start && !busy) || valid_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int span;
    int n_run;
    // directed: idle, extremes, slot reload, ties, preemption, zero burst
    idle_mode = 1;
    push_cmd(OP_TICK, 4'd0, '0, '0, '0, '0);
    push_cmd(OP_NOP, 4'd0, '0, '0, '0, '0);
    push_cmd(OP_LOAD, 4'd0, 16'hFFFF, 20'd0, 16'd3, 8'hFF);
    push_cmd(OP_TICK, 4'd0, '0, '0, '0, '0);
    push_cmd(OP_LOAD, 4'd0, 16'hFFFF, 20'd0, 16'd3, 8'hFF);
    push_cmd(OP_TICK, 4'd0, '0, '0, '0, '0);
    push_cmd(OP_LOAD, 4'd15, 16'd0, 20'd0, 16'd1, 8'd0);
    push_cmd(OP_LOAD, 4'd7, 16'd0, 20'd0, 16'd2, 8'd0);
    push_cmd(OP_LOAD, 4'd9, 16'd1, 20'd0, 16'd0, 8'd0);
    push_cmd(OP_LOAD, 4'd4, 16'd2, 20'hFFFFF, 16'hFFFF, 8'd0);
    push_cmd(OP_LOAD, 4'd5, 16'd3, 20'd6, 16'd1, 8'd1);
    repeat (10) push_cmd(OP_TICK, 4'd0, '0, '0, '0, '0);
    push_cmd(OP_NOP, 4'hF, 16'hFFFF, 20'hFFFFF, 16'hFFFF, 8'hFF);
    push_cmd(OP_CLEAR, 4'd0, '0, '0, '0, '0);
    push_cmd(OP_TICK, 4'd0, '0, '0, '0, '0);

    while (n_items < ITEM_TARGET) begin
      idle_mode = $urandom_range(0, 2);
      hold_next = (n_items < 30) || ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 4) != 0) push_cmd(OP_CLEAR, '0, '0, '0, '0, '0);
        span = 0;
        repeat ($urandom_range(1, 6)) load_random_task(span);
        n_run = span + 8 + $urandom_range(0, 3);
        repeat (n_run) begin
          case ($urandom_range(0, 15))
            0:       load_random_task(span);
            1:       push_cmd(OP_NOP, SLOT_IN_W'($urandom), '0, '0, '0, '0);
            default: ;
          endcase
          push_cmd(OP_TICK, SLOT_IN_W'($urandom), PID_W'($urandom), ARR_W'($urandom),
                   BURST_W'($urandom), PRIO_W'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 8))
          push_cmd(opcode_e'($urandom_range(0, 3)), SLOT_IN_W'($urandom), PID_W'($urandom),
                   ARR_W'($urandom), BURST_W'($urandom), PRIO_W'($urandom));
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || have_cmd || outstanding != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (pending_outcomes.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_outcomes.size()));

    $display("Run covered %0d transactions, %0d of them ticks (%0d idle).",
             n_accepted, n_ticks, n_idle);
    $display("Schedules produced %0d dispatches and %0d task completions.",
             n_dispatch, n_finish);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/pps_pkg.sv
sv/pps_cell.sv
sv/preemptive_priority_scheduler_unit.sv
tb/preemptive_priority_scheduler_unit_test.sv
